// ===== hw/rtl/arm_pr_pkg.sv =====
// Shared types, opcodes and helpers of the AArch64 peephole rewriter.
`timescale 1ns / 1ps
package arm_pr_pkg;

  // Largest op buffer the count fields must cover.
  localparam int unsigned OP_WORDS_MAX = 64;
  localparam int unsigned OP_WORDS_DEF = 64;
  localparam int unsigned CNT_W        = $clog2(OP_WORDS_MAX + 1);

  // Opcodes and masks.
  localparam logic [31:0] NOP_WORD  = 32'hD503201F;
  localparam logic [31:0] B_MASK    = 32'hFC000000;
  localparam logic [31:0] B_OPC     = 32'h14000000;
  localparam logic [31:0] B_OFS     = 32'h03FFFFFF;
  localparam logic [31:0] PRFM_MASK = 32'hFFC00000;
  localparam logic [31:0] PRFM_OPC  = 32'hF9800000;
  localparam logic [31:0] MOVW_MASK = 32'hFF800000;
  localparam logic [31:0] MOVZ_OPC  = 32'hD2800000;
  localparam logic [31:0] MOVK_OPC  = 32'hF2800000;
  localparam logic [31:0] UBFM_MASK = 32'h7F800000;
  localparam logic [31:0] UBFM_OPC  = 32'h53000000;

  // Job handed from front to back when an op is complete.
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] lim;
    logic             ovf;
    logic             clr;
  } job_t;

  // Buffer write request.
  typedef struct packed {
    logic             we;
    logic [CNT_W-1:0] addr;
    logic [31:0]      data;
  } wr_t;

  // One result entry.
  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic [31:0] prfm;
    logic [31:0] br;
    logic [31:0] fold;
    logic        ovf;
  } res_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_CHK,
    B_RD0,
    B_EV0,
    B_RDF,
    B_EVF,
    B_SHIFT,
    B_WR,
    B_ERD,
    B_EWR
  } back_state_e;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFFFFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic names_reg(input logic [31:0] w, input logic [4:0] r);
    return (w[4:0] == r) || (w[9:5] == r) || (w[20:16] == r) || (w[14:10] == r);
  endfunction

endpackage

// ===== hw/rtl/arm_pr_front.sv =====
// Front end: accepts op words, fills the buffer, tracks block limit and overflow.
`timescale 1ns / 1ps
module arm_pr_front #(
  parameter int unsigned OP_WORDS = arm_pr_pkg::OP_WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [31:0]       word_i,
  input  logic              last_word_i,
  input  logic              in_block_i,
  input  logic              new_block_i,
  input  logic              back_busy_i,
  input  logic              job_take_i,
  output logic              job_valid_o,
  output arm_pr_pkg::job_t  job_o,
  output arm_pr_pkg::wr_t   wr_o
);
  import arm_pr_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH = CNT_W'(OP_WORDS);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] lim_q, lim_d;
  logic             ovf_q, ovf_d;
  logic             clr_q, clr_d;
  logic             jv_q, jv_d;
  job_t             job_q, job_d;
  logic             acc;

  // Hold off new words while a job waits or the back end works.
  assign full        = jv_q | back_busy_i;
  assign acc         = push & ~full;
  assign job_valid_o = jv_q;
  assign job_o       = job_q;

  // Track the op being loaded and hand it over on its last word.
  always_comb begin
    cnt_d = cnt_q;
    lim_d = lim_q;
    ovf_d = ovf_q;
    clr_d = clr_q;
    jv_d  = jv_q & ~job_take_i;
    job_d = job_q;
    wr_o  = '{we: 1'b0, addr: cnt_q, data: word_i};
    if (acc) begin
      if (new_block_i) clr_d = 1'b1;
      if (cnt_q < DEPTH) begin
        wr_o.we = 1'b1;
        if (in_block_i && lim_q == cnt_q) lim_d = cnt_q + CNT_W'(1);
        cnt_d = cnt_q + CNT_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
      if (last_word_i) begin
        jv_d  = 1'b1;
        job_d = '{n: cnt_d, lim: lim_d, ovf: ovf_d, clr: clr_d};
        cnt_d = '0;
        lim_d = '0;
        ovf_d = 1'b0;
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      lim_q <= '0;
      ovf_q <= 1'b0;
      clr_q <= 1'b0;
      jv_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      lim_q <= lim_d;
      ovf_q <= ovf_d;
      clr_q <= clr_d;
      jv_q  <= jv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

endmodule

// ===== hw/rtl/arm_pr_back.sv =====
// Back end: op buffer, rewrite sequencer with fold search, and result emission.
`timescale 1ns / 1ps
module arm_pr_back #(
  parameter int unsigned OP_WORDS = arm_pr_pkg::OP_WORDS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  arm_pr_pkg::wr_t  fr_wr_i,
  input  logic             job_valid_i,
  input  arm_pr_pkg::job_t job_i,
  output logic             job_take_o,
  output logic             busy_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output arm_pr_pkg::res_t res_o
);
  import arm_pr_pkg::*;

  localparam int unsigned AW = $clog2(OP_WORDS);

  logic [31:0] mem [OP_WORDS];
  logic [31:0] rd_q;
  wr_t         bk_wr, wr;

  back_state_e st_q, st_d;
  logic [CNT_W-1:0] i_q, i_d, ptr_q, ptr_d, n_q, n_d, lim_q, lim_d;
  logic [2:0]  k_q, k_d;
  logic [4:0]  reg_q, reg_d, dst_q, dst_d;
  logic [5:0]  immr_q, immr_d, diff_q, diff_d;
  logic [63:0] val_q, val_d, sh_q, sh_d, msk_q, msk_d, fld;
  logic        ovf_q, ovf_d;
  logic [31:0] prfm_q, prfm_d, br_q, br_d, fold_q, fold_d;
  logic [31:0] x1, x2;
  logic        is_prfm, is_br;
  logic [5:0]  u_immr, u_imms;
  logic [CNT_W:0] i_end, ptr_nx;

  // Buffer: one write port shared by both ends, registered read.
  assign wr = fr_wr_i.we ? fr_wr_i : bk_wr;
  always_ff @(posedge clk_i) begin
    if (wr.we) mem[wr.addr[AW-1:0]] <= wr.data;
    rd_q <= mem[ptr_q[AW-1:0]];
  end

  assign busy_o  = (st_q != B_IDLE);
  assign is_prfm = (rd_q & PRFM_MASK) == PRFM_OPC;
  assign x1      = is_prfm ? NOP_WORD : rd_q;
  assign is_br   = ((x1 & B_MASK) == B_OPC) && ((x1 & B_OFS) == 32'd1);
  assign x2      = is_br ? NOP_WORD : x1;
  assign u_immr  = rd_q[21:16];
  assign u_imms  = rd_q[15:10];
  assign i_end   = {1'b0, i_q} + (CNT_W+1)'(5);
  assign ptr_nx  = {1'b0, ptr_q} + (CNT_W+1)'(1);
  assign fld     = sh_q & msk_q;

  // Sequence rewrite, fold search and emission.
  always_comb begin
    st_d   = st_q;
    i_d    = i_q;
    ptr_d  = ptr_q;
    n_d    = n_q;
    lim_d  = lim_q;
    k_d    = k_q;
    reg_d  = reg_q;
    dst_d  = dst_q;
    immr_d = immr_q;
    diff_d = diff_q;
    val_d  = val_q;
    sh_d   = sh_q;
    msk_d  = msk_q;
    ovf_d  = ovf_q;
    prfm_d = prfm_q;
    br_d   = br_q;
    fold_d = fold_q;
    job_take_o = 1'b0;
    res_push_o = 1'b0;
    bk_wr  = '{we: 1'b0, addr: i_q, data: x2};
    res_o  = '{word: rd_q, last: (ptr_nx == {1'b0, n_q}), prfm: prfm_q, br: br_q,
               fold: fold_q, ovf: ovf_q};
    unique case (st_q)
      B_IDLE: begin
        if (job_valid_i) begin
          job_take_o = 1'b1;
          n_d   = job_i.n;
          lim_d = job_i.lim;
          ovf_d = job_i.ovf;
          if (job_i.clr) begin
            prfm_d = '0;
            br_d   = '0;
            fold_d = '0;
          end
          i_d  = '0;
          st_d = B_CHK;
        end
      end
      B_CHK: begin
        if (i_q >= lim_q || i_q >= n_q) begin
          ptr_d = '0;
          st_d  = B_ERD;
        end else begin
          ptr_d = i_q;
          st_d  = B_RD0;
        end
      end
      B_RD0: st_d = B_EV0;
      B_EV0: begin
        // Drop prefetches and branches to the next word, then look for a fold.
        if (is_prfm) prfm_d = sat_inc(prfm_q);
        if (is_br) br_d = sat_inc(br_q);
        bk_wr.we = is_prfm | is_br;
        if (i_end <= {1'b0, n_q} && (x2 & MOVW_MASK) == MOVZ_OPC) begin
          reg_d = x2[4:0];
          val_d = '0;
          val_d[16*x2[22:21] +: 16] = x2[20:5];
          k_d   = 3'd1;
          ptr_d = i_q + CNT_W'(1);
          st_d  = B_RDF;
        end else begin
          i_d  = i_q + CNT_W'(1);
          st_d = B_CHK;
        end
      end
      B_RDF: st_d = B_EVF;
      B_EVF: begin
        i_d  = i_q + CNT_W'(1);
        st_d = B_CHK;
        if (k_q < 3'd4) begin
          if (rd_q[4:0] == reg_q && (rd_q & MOVW_MASK) == MOVK_OPC) begin
            val_d[16*rd_q[22:21] +: 16] = rd_q[20:5];
            k_d   = k_q + 3'd1;
            ptr_d = ptr_q + CNT_W'(1);
            i_d   = i_q;
            st_d  = B_RDF;
          end
        end else if (k_q == 3'd4) begin
          if ((rd_q & UBFM_MASK) == UBFM_OPC && rd_q[9:5] == reg_q && rd_q[31] &&
              rd_q[22] && u_imms >= u_immr && val_q != '1) begin
            dst_d  = rd_q[4:0];
            immr_d = u_immr;
            diff_d = u_imms - u_immr;
            k_d    = 3'd5;
            ptr_d  = ptr_q + CNT_W'(1);
            i_d    = i_q;
            st_d   = (ptr_nx >= {1'b0, n_q}) ? B_SHIFT : B_RDF;
          end
        end else begin
          // Scan the rest of the op for any use of the register.
          if (!names_reg(rd_q, reg_q)) begin
            ptr_d = ptr_q + CNT_W'(1);
            i_d   = i_q;
            st_d  = (ptr_nx >= {1'b0, n_q}) ? B_SHIFT : B_RDF;
          end
        end
      end
      B_SHIFT: begin
        sh_d  = val_q >> immr_q;
        msk_d = {64{1'b1}} >> (6'd63 - diff_q);
        k_d   = '0;
        st_d  = B_WR;
      end
      B_WR: begin
        // Write the folded mov-wide sequence, then NOP.
        bk_wr.we   = 1'b1;
        bk_wr.addr = i_q + CNT_W'(k_q);
        if (k_q == 3'd4) begin
          bk_wr.data = NOP_WORD;
          fold_d     = sat_inc(fold_q);
          i_d        = i_q + CNT_W'(5);
          st_d       = B_CHK;
        end else begin
          bk_wr.data = ((k_q == 3'd0) ? MOVZ_OPC : MOVK_OPC) |
                       {9'd0, k_q[1:0], fld[16*k_q[1:0] +: 16], dst_q};
          k_d = k_q + 3'd1;
        end
      end
      B_ERD: begin
        if (!res_full_i) st_d = B_EWR;
      end
      B_EWR: begin
        res_push_o = 1'b1;
        if (ptr_nx == {1'b0, n_q}) begin
          st_d = B_IDLE;
        end else begin
          ptr_d = ptr_q + CNT_W'(1);
          st_d  = B_ERD;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= B_IDLE;
      prfm_q <= '0;
      br_q   <= '0;
      fold_q <= '0;
    end else begin
      st_q   <= st_d;
      prfm_q <= prfm_d;
      br_q   <= br_d;
      fold_q <= fold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    ptr_q  <= ptr_d;
    n_q    <= n_d;
    lim_q  <= lim_d;
    k_q    <= k_d;
    reg_q  <= reg_d;
    dst_q  <= dst_d;
    immr_q <= immr_d;
    diff_q <= diff_d;
    val_q  <= val_d;
    sh_q   <= sh_d;
    msk_q  <= msk_d;
    ovf_q  <= ovf_d;
  end

endmodule

// ===== hw/rtl/arm_pr_ofifo.sv =====
// Two-entry result queue between the back end and the result port.
`timescale 1ns / 1ps
module arm_pr_ofifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  arm_pr_pkg::res_t data_i,
  output logic             full_o,
  output logic             empty,
  input  logic             pop,
  output arm_pr_pkg::res_t data_o
);
  import arm_pr_pkg::*;

  res_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign full_o = (cnt_q == 2'd2);
  assign empty  = (cnt_q == 2'd0);
  assign data_o = ent_q[rp_q];
  assign do_pop = pop & ~empty;

  // Advance pointers and count on each transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= data_i;
  end

endmodule

// ===== hw/rtl/arm64_peephole_rewriter.sv =====
// Top level of the AArch64 peephole rewriter.
//
//   channel   handshake          payload
//   input     push / full        word_i, last_word_i, in_block_i, new_block_i
//   result    empty / pop        word_out_o, last_out_o, *_count_o, overflow_o
//
// Words load one per cycle into the op buffer while full is low. After the last word
// the back end rewrites the op word by word (check, read, evaluate); a fold
// candidate reads on to the op end, then writes the folded sequence. Emission reads
// each word, then pushes it; the single buffer read port sets all of this.
// full stays high from the last word until the op is emitted; pop stalls only
// emission. Reset clears the counters and control state; the buffer is not cleared.
`timescale 1ns / 1ps
module arm64_peephole_rewriter #(
  parameter int unsigned OP_WORDS = arm_pr_pkg::OP_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] word_i,
  input  logic        last_word_i,
  input  logic        in_block_i,
  input  logic        new_block_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] word_out_o,
  output logic        last_out_o,
  output logic [31:0] prfm_count_o,
  output logic [31:0] branch_count_o,
  output logic [31:0] fold_count_o,
  output logic        overflow_o
);
  import arm_pr_pkg::*;

  logic back_busy, job_valid, job_take, res_full, res_push;
  job_t job;
  wr_t  fr_wr;
  res_t res_in, res_out;

  arm_pr_front #(.OP_WORDS(OP_WORDS)) u_front (
    .clk_i, .rst_ni, .push, .full, .word_i, .last_word_i, .in_block_i, .new_block_i,
    .back_busy_i(back_busy), .job_take_i(job_take), .job_valid_o(job_valid),
    .job_o(job), .wr_o(fr_wr)
  );

  arm_pr_back #(.OP_WORDS(OP_WORDS)) u_back (
    .clk_i, .rst_ni, .fr_wr_i(fr_wr), .job_valid_i(job_valid), .job_i(job),
    .job_take_o(job_take), .busy_o(back_busy), .res_full_i(res_full),
    .res_push_o(res_push), .res_o(res_in)
  );

  arm_pr_ofifo u_ofifo (
    .clk_i, .rst_ni, .push_i(res_push), .data_i(res_in), .full_o(res_full),
    .empty, .pop, .data_o(res_out)
  );

  assign word_out_o     = res_out.word;
  assign last_out_o     = res_out.last;
  assign prfm_count_o   = res_out.prfm;
  assign branch_count_o = res_out.br;
  assign fold_count_o   = res_out.fold;
  assign overflow_o     = res_out.ovf;

  // Front never writes the buffer while the back end owns it.
  a_no_wr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_wr.we |-> !back_busy) else $error("buffer written while back end busy");

  // A waiting job stays until the back end takes it.
  a_job_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid && !job_take |=> job_valid) else $error("job lost");

  // A job is taken only by an idle back end.
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_take |-> job_valid && !back_busy) else $error("job taken while busy");

endmodule

// ===== bench/arm64_peephole_rewriter_check.sv =====
// Checker for the AArch64 peephole rewriter: predicts each op and compares results.
`timescale 1ns / 1ps
module arm64_peephole_rewriter_check #(
  parameter int unsigned OP_WORDS = arm_pr_pkg::OP_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [31:0] word_i,
  input  logic        last_word_i,
  input  logic        in_block_i,
  input  logic        new_block_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] word_out_o,
  input  logic        last_out_o,
  input  logic [31:0] prfm_count_o,
  input  logic [31:0] branch_count_o,
  input  logic [31:0] fold_count_o,
  input  logic        overflow_o,
  output int          fail_count,
  output int          pending,
  output int          checked
);
  import arm_pr_pkg::*;

  // Shadow copy of the op buffer and the per-block totals.
  logic [31:0] shadow_buf [OP_WORDS];
  int unsigned op_len;
  int unsigned lead_in;
  logic [31:0] prfm_tot, br_tot, fold_tot;
  logic        op_dropped;
  res_t        rewritten_q [$];

  assign pending = rewritten_q.size();

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFFFFFF) ? v : v + 32'd1;
  endfunction

  // Fold the mov-wide window at p into the UBFM destination when legal.
  function automatic bit fold_window(input int unsigned p, input int unsigned n);
    logic [4:0]  r;
    logic [63:0] val, msk, fld;
    logic [31:0] w, use_w;
    int unsigned sh, immr, imms, wid;
    r   = shadow_buf[p][4:0];
    val = '0;
    for (int k = 0; k < 4; k++) begin
      w  = shadow_buf[p + k];
      sh = 16 * w[22:21];
      if (w[4:0] != r) return 1'b0;
      if ((w & MOVW_MASK) != ((k == 0) ? MOVZ_OPC : MOVK_OPC)) return 1'b0;
      val &= ~(64'hFFFF << sh);
      val |= 64'(w[20:5]) << sh;
    end
    if (val == '1) return 1'b0;
    use_w = shadow_buf[p + 4];
    if ((use_w & UBFM_MASK) != UBFM_OPC || use_w[9:5] != r) return 1'b0;
    if (!use_w[31] || !use_w[22]) return 1'b0;
    immr = use_w[21:16];
    imms = use_w[15:10];
    if (imms < immr) return 1'b0;
    for (int unsigned k = p + 5; k < n; k++) begin
      w = shadow_buf[k];
      if (w[4:0] == r || w[9:5] == r || w[20:16] == r || w[14:10] == r) return 1'b0;
    end
    wid = imms - immr + 1;
    msk = (wid >= 64) ? '1 : ((64'd1 << wid) - 64'd1);
    fld = (val >> immr) & msk;
    for (int k = 0; k < 4; k++) begin
      shadow_buf[p + k] = ((k == 0) ? MOVZ_OPC : MOVK_OPC) | (32'(k) << 21)
                          | (32'(fld[16*k +: 16]) << 5) | 32'(use_w[4:0]);
    end
    shadow_buf[p + 4] = NOP_WORD;
    return 1'b1;
  endfunction

  // Absorb one transferred word; on the last word rewrite and queue the op.
  task automatic absorb_word(input logic [31:0] w, input logic last, input logic inb,
                             input logic nb);
    int unsigned i;
    logic [31:0] x;
    res_t        r;
    if (nb) begin
      prfm_tot = '0;
      br_tot   = '0;
      fold_tot = '0;
    end
    if (op_len < OP_WORDS) begin
      shadow_buf[op_len] = w;
      if (inb && lead_in == op_len) lead_in = op_len + 1;
      op_len++;
    end else begin
      op_dropped = 1'b1;
    end
    if (!last) return;
    i = 0;
    while (i < op_len && i < lead_in) begin
      x = shadow_buf[i];
      if ((x & PRFM_MASK) == PRFM_OPC) begin
        x        = NOP_WORD;
        prfm_tot = bump(prfm_tot);
      end
      if ((x & B_MASK) == B_OPC && (x & B_OFS) == 32'd1) begin
        x      = NOP_WORD;
        br_tot = bump(br_tot);
      end
      shadow_buf[i] = x;
      if (i + 5 <= op_len && fold_window(i, op_len)) begin
        fold_tot = bump(fold_tot);
        i += 4;
      end
      i++;
    end
    for (int unsigned k = 0; k < op_len; k++) begin
      r.word = shadow_buf[k];
      r.last = (k + 1 == op_len);
      r.prfm = prfm_tot;
      r.br   = br_tot;
      r.fold = fold_tot;
      r.ovf  = op_dropped;
      rewritten_q.push_back(r);
    end
    op_len     = 0;
    lead_in    = 0;
    op_dropped = 1'b0;
  endtask

  // Clear the model in reset; otherwise watch both channels at each rising edge.
  always @(posedge clk_i) begin
    res_t e;
    if (!rst_ni) begin
      fail_count = 0;
      checked    = 0;
      op_len     = 0;
      lead_in    = 0;
      prfm_tot   = '0;
      br_tot     = '0;
      fold_tot   = '0;
      op_dropped = 1'b0;
      rewritten_q.delete();
    end else begin
      if (pop && !empty) begin
        checked++;
        if (rewritten_q.size() == 0) begin
          $error("result 0x%08h with no expected word waiting", word_out_o);
          fail_count++;
        end else begin
          e = rewritten_q.pop_front();
          if (word_out_o !== e.word) begin
            $error("word_out: expected 0x%08h, got 0x%08h", e.word, word_out_o);
            fail_count++;
          end
          if (last_out_o !== e.last) begin
            $error("last_out: expected %0d, got %0d", e.last, last_out_o);
            fail_count++;
          end
          if (prfm_count_o !== e.prfm) begin
            $error("prfm_count: expected %0d, got %0d", e.prfm, prfm_count_o);
            fail_count++;
          end
          if (branch_count_o !== e.br) begin
            $error("branch_count: expected %0d, got %0d", e.br, branch_count_o);
            fail_count++;
          end
          if (fold_count_o !== e.fold) begin
            $error("fold_count: expected %0d, got %0d", e.fold, fold_count_o);
            fail_count++;
          end
          if (overflow_o !== e.ovf) begin
            $error("overflow: expected %0d, got %0d", e.ovf, overflow_o);
            fail_count++;
          end
        end
      end
      if (push && !full) absorb_word(word_i, last_word_i, in_block_i, new_block_i);
    end
  end

endmodule

// ===== bench/arm64_peephole_rewriter_test.sv =====
// Stimulus and verdict for the AArch64 peephole rewriter.
`timescale 1ns / 1ps
module arm64_peephole_rewriter_test;
  import arm_pr_pkg::*;

  localparam int unsigned WORD_TARGET = 270;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_WAIT  = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] word_i = '0;
  logic        last_word_i = 1'b0;
  logic        in_block_i = 1'b0;
  logic        new_block_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] word_out_o;
  logic        last_out_o;
  logic [31:0] prfm_count_o, branch_count_o, fold_count_o;
  logic        overflow_o;
  int          fail_count, pending, checked;
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  int unsigned ops_sent = 0;

  logic [31:0] op_w [$];
  logic        op_ib [$];
  logic        op_nb [$];

  arm64_peephole_rewriter u_top (.*);

  arm64_peephole_rewriter_check u_check (.*);

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abort on a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the result side: mostly short stalls, runs with none, a few long ones.
  int unsigned pop_hold = 0;
  always @(posedge clk_i) begin
    if (pop_hold > 0) begin
      pop      <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 5) == 0) pop_hold <= gap_len();
    end
  end

  task automatic add_word(input logic [31:0] w, input logic ib, input logic nb);
    op_w.push_back(w);
    op_ib.push_back(ib);
    op_nb.push_back(nb);
  endtask

  // Transfer the collected op word by word, last word flagged.
  task automatic send_op();
    int unsigned g;
    logic        f;
    for (int k = 0; k < op_w.size(); k++) begin
      g = gap_len();
      if (g > 0) begin
        push <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      push        <= 1'b1;
      word_i      <= op_w[k];
      last_word_i <= (k == op_w.size() - 1);
      in_block_i  <= op_ib[k];
      new_block_i <= op_nb[k];
      do begin
        @(negedge clk_i);
        f = full;
        @(posedge clk_i);
      end while (f);
      words_sent++;
    end
    push <= 1'b0;
    ops_sent++;
    op_w.delete();
    op_ib.delete();
    op_nb.delete();
  endtask

  function automatic logic [31:0] ubfm64(input logic [5:0] immr, input logic [5:0] imms,
                                         input logic [4:0] rn, input logic [4:0] rd);
    return 32'hD3400000 | (32'(immr) << 16) | (32'(imms) << 10) | (32'(rn) << 5) | 32'(rd);
  endfunction

  function automatic logic [31:0] movw(input logic movk, input logic [1:0] hw,
                                       input logic [15:0] imm, input logic [4:0] rd);
    return (movk ? MOVK_OPC : MOVZ_OPC) | (32'(hw) << 21) | (32'(imm) << 5) | 32'(rd);
  endfunction

  // Mov-wide window plus UBFM on register r, with random content.
  task automatic add_fold_window(input logic [4:0] r, input logic ib);
    logic [5:0] immr, imms;
    bool_all: begin
      logic ones;
      ones = ($urandom_range(0, 30) == 0);
      for (int k = 0; k < 4; k++) begin
        add_word(movw(k != 0, ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'(k),
                      ones ? 16'hFFFF : 16'($urandom), r), ib, 1'b0);
      end
    end
    immr = 6'($urandom);
    imms = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(immr, 63));
    add_word(ubfm64(immr, imms, ($urandom_range(0, 9) == 0) ? 5'($urandom) : r,
                    5'($urandom)), ib, 1'b0);
  endtask

  function automatic logic [31:0] filler_word();
    case ($urandom_range(0, 7))
      0: return PRFM_OPC | ($urandom & 32'h003FFFFF);
      1: return B_OPC | 32'd1;
      2: return B_OPC | ($urandom & B_OFS);
      3: return NOP_WORD;
      4: return movw(1'($urandom_range(0, 1)), 2'($urandom), 16'($urandom), 5'($urandom));
      default: return $urandom;
    endcase
  endfunction

  // Flip the low bit of any register field that names r.
  function automatic logic [31:0] spare_reg(input logic [31:0] w, input logic [4:0] r);
    if (w[4:0] == r) w[0] = ~w[0];
    if (w[9:5] == r) w[5] = ~w[5];
    if (w[14:10] == r) w[10] = ~w[10];
    if (w[20:16] == r) w[16] = ~w[16];
    return w;
  endfunction

  // Build one random op: mostly short, a few overlong, often with a fold window.
  task automatic build_random_op();
    int unsigned len, cut, at;
    logic [4:0]  r;
    logic        guard;
    len = ($urandom_range(0, 60) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 12);
    cut = ($urandom_range(0, 99) < 80) ? len : $urandom_range(0, len);
    at  = (len >= 5 && $urandom_range(0, 1)) ? $urandom_range(0, len - 5) : len;
    r   = 5'($urandom);
    guard = ($urandom_range(0, 4) != 0);
    for (int unsigned k = 0; k < len; k++) begin
      if (k == at) begin
        add_fold_window(r, (k < cut) ? 1'b1 : 1'($urandom));
        k += 4;
      end else begin
        add_word((k > at && guard) ? spare_reg(filler_word(), r) : filler_word(),
                 (k < cut) ? 1'b1 : 1'($urandom),
                 (k == 0) ? ($urandom_range(0, 6) == 0) : ($urandom_range(0, 40) == 0));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Prefetch, branch to next, other branch, NOP; new block.
    add_word(PRFM_OPC | 32'h003FFFFF, 1'b1, 1'b1);
    add_word(B_OPC | 32'd1, 1'b1, 1'b0);
    add_word(B_OPC | 32'd2, 1'b1, 1'b0);
    add_word(NOP_WORD, 1'b1, 1'b0);
    send_op();
    // Clean fold followed by an unrelated word.
    for (int k = 0; k < 4; k++) begin
      add_word(movw(k != 0, 2'(k), 16'hA5C3 ^ 16'(k), 5'd3), 1'b1, 1'b0);
    end
    add_word(ubfm64(6'd4, 6'd63, 5'd3, 5'd7), 1'b1, 1'b0);
    add_word(32'h8B020020, 1'b1, 1'b0);
    send_op();
    // All-ones value: no fold; full-width UBFM.
    for (int k = 0; k < 4; k++) add_word(movw(k != 0, 2'(k), 16'hFFFF, 5'd31), 1'b1, 1'b0);
    add_word(ubfm64(6'd0, 6'd63, 5'd31, 5'd0), 1'b1, 1'b0);
    send_op();
    // Out-of-block from the second word on: prefetch passes unchanged.
    add_word(B_OPC | 32'd1, 1'b1, 1'b1);
    add_word(PRFM_OPC, 1'b0, 1'b0);
    add_word(PRFM_OPC, 1'b1, 1'b0);
    send_op();
    // Field extremes and a 32-bit mov-wide window that must not fold.
    add_word(32'hFFFFFFFF, 1'b1, 1'b0);
    send_op();
    add_word(32'h00000000, 1'b0, 1'b0);
    send_op();
    for (int k = 0; k < 4; k++) add_word(movw(k != 0, 2'(k), 16'h1234, 5'd1) & 32'h7FFFFFFF,
                                         1'b1, 1'b0);
    add_word(ubfm64(6'd8, 6'd15, 5'd1, 5'd2), 1'b1, 1'b0);
    send_op();

    // Let everything drain before the random part.
    while (pending != 0) @(posedge clk_i);

    while (words_sent < WORD_TARGET) begin
      build_random_op();
      send_op();
    end

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Transferred %0d words in %0d ops; checked %0d rewritten words.",
             words_sent, ops_sent, checked);
    $display("Covered prefetch and branch removal, folds, block ends, overlong ops.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
